// ===== hw/rtl/efl_pkg.sv =====
// ----------------------------------------------------------------------------
// Escalating failure lockout package
// Shared widths, codes, reset values and types for the lockout core.
// ----------------------------------------------------------------------------
package efl_pkg;

  localparam int unsigned KindW   = 2;
  localparam int unsigned CodeW   = 8;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 16;
  localparam int unsigned MsW     = 24;
  localparam int unsigned SecW    = 15;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 24;

  localparam int unsigned StepCountDef = 5;
  localparam int unsigned StepMax      = 5;

  // Reciprocal of 1000 scaled by 2**34; exact floor for any 24-bit dividend.
  localparam int unsigned RecipW     = 25;
  localparam int unsigned RecipShift = 34;
  localparam logic [RecipW-1:0] Recip1000 = 25'd17179870;

  localparam logic [CfgIdxW-1:0] CFG_FAIL_THRESHOLD = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOCK_MS_STEP0  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_CODE   = 3'd6;

  localparam logic [CodeW-1:0] FailThresholdRst = 8'd5;
  localparam logic [CodeW-1:0] TimeoutCodeRst   = 8'd8;
  localparam logic [MsW-1:0]   LockMsRst [StepMax] = '{
    24'd5000, 24'd15000, 24'd60000, 24'd300000, 24'd900000
  };

  localparam logic [CodeW-1:0] MatchCodeLo = 8'd1;
  localparam logic [CodeW-1:0] MatchCodeHi = 8'd3;

  typedef enum logic [KindW-1:0] {
    KIND_TICK    = 2'd0,
    KIND_REPLY   = 2'd1,
    KIND_RESTORE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    VERDICT_NONE    = 3'd0,
    VERDICT_MATCH   = 3'd1,
    VERDICT_TIMEOUT = 3'd2,
    VERDICT_FAIL    = 3'd3,
    VERDICT_LOCKED  = 3'd4
  } verdict_e;

  typedef struct packed {
    logic [CodeW-1:0] fail_limit;
    logic [CodeW-1:0] timeout_code;
  } cfg_t;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [CodeW-1:0]  reply_code;
    logic [ByteW-1:0]  id_high;
    logic [ByteW-1:0]  id_low;
    logic [CountW-1:0] restore_count;
  } item_t;

  typedef struct packed {
    verdict_e          verdict;
    logic [CountW-1:0] user_id;
    logic              locked;
    logic [MsW-1:0]    remaining_ms;
    logic [CountW-1:0] failure_total;
    logic              persist_request;
  } mid_t;

  typedef struct packed {
    verdict_e          verdict;
    logic [CountW-1:0] user_id;
    logic              locked;
    logic [SecW-1:0]   secs_left;
    logic [CountW-1:0] failure_total;
    logic              persist_request;
  } res_t;

endpackage

// ===== hw/rtl/efl_in_if.sv =====
// ----------------------------------------------------------------------------
// Lockout input channel
// Valid/ready channel carrying one tick, matcher reply or count restore.
// ----------------------------------------------------------------------------
interface efl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  reply_code;
  logic [7:0]  id_high;
  logic [7:0]  id_low;
  logic [15:0] restore_count;

  modport source (output valid, kind, reply_code, id_high, id_low, restore_count,
                  input ready);
  modport sink   (input valid, kind, reply_code, id_high, id_low, restore_count,
                  output ready);
endinterface

// ===== hw/rtl/efl_out_if.sv =====
// ----------------------------------------------------------------------------
// Lockout result channel
// Valid/ready channel carrying the verdict and lock status of one item.
// ----------------------------------------------------------------------------
interface efl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [15:0] user_id;
  logic        locked;
  logic [14:0] secs_left;
  logic [15:0] failure_total;
  logic        persist_request;

  modport source (output valid, verdict, user_id, locked, secs_left, failure_total,
                  persist_request, input ready);
  modport sink   (input valid, verdict, user_id, locked, secs_left, failure_total,
                  persist_request, output ready);
endinterface

// ===== hw/rtl/efl_cfg.sv =====
// ----------------------------------------------------------------------------
// Lockout configuration registers
// Holds the threshold, the timeout code and the lock duration table.
// ----------------------------------------------------------------------------
module efl_cfg
  import efl_pkg::*;
#(
  parameter int unsigned STEP_COUNT = StepCountDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  output cfg_t               cfg_o,
  output logic [MsW-1:0]     lock_ms_o [STEP_COUNT]
);

  cfg_t           cfg_q;
  logic [MsW-1:0] lock_ms_q [STEP_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fail_limit   <= FailThresholdRst;
      cfg_q.timeout_code <= TimeoutCodeRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_FAIL_THRESHOLD) begin
        cfg_q.fail_limit <= cfg_wdata_i[CodeW-1:0];
      end
      if (cfg_idx_i == CFG_TIMEOUT_CODE) begin
        cfg_q.timeout_code <= cfg_wdata_i[CodeW-1:0];
      end
    end
  end

  for (genvar g = 0; g < STEP_COUNT; g++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lock_ms_q[g] <= LockMsRst[g];
      end else if (cfg_we_i && (cfg_idx_i == CfgIdxW'(CFG_LOCK_MS_STEP0 + g))) begin
        lock_ms_q[g] <= cfg_wdata_i[MsW-1:0];
      end
    end
  end

  assign cfg_o     = cfg_q;
  assign lock_ms_o = lock_ms_q;

endmodule

// ===== hw/rtl/efl_update.sv =====
// ----------------------------------------------------------------------------
// Lockout state update stage
// Registers the input item and applies it to the failure count and lock state.
// ----------------------------------------------------------------------------
module efl_update
  import efl_pkg::*;
#(
  parameter int unsigned STEP_COUNT = StepCountDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  efl_in_if.sink         item_i,
  input  cfg_t           cfg_i,
  input  logic [MsW-1:0] lock_ms_i [STEP_COUNT],
  output logic           mid_valid_o,
  input  logic           mid_ready_i,
  output mid_t           mid_o
);

  localparam int unsigned StepIdxW = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;
  localparam logic [StepIdxW-1:0] LastStep = StepIdxW'(STEP_COUNT - 1);

  logic              in_valid_q;
  item_t             in_q;
  logic              mid_valid_q;
  mid_t              mid_q;
  logic [CountW-1:0] count_q, count_d;
  logic [MsW-1:0]    rem_q, rem_d;
  logic              lock_q, lock_d;

  logic              en_mid, en_in;
  logic [CountW-1:0] count_inc, arm_cnt, excess;
  logic [StepIdxW-1:0] step_idx;
  logic [MsW-1:0]    dur, rem_dec;
  logic              arm_lock;
  logic [MsW-1:0]    arm_rem;
  verdict_e          verdict;
  logic [CountW-1:0] user_id;
  logic              persist;

  assign en_mid       = !mid_valid_q || mid_ready_i;
  assign en_in        = !in_valid_q || en_mid;
  assign item_i.ready = en_in;

  always_comb begin
    count_inc = (count_q == '1) ? count_q : count_q + CountW'(1);
    arm_cnt   = (in_q.kind == KIND_RESTORE) ? in_q.restore_count : count_inc;
    excess    = arm_cnt - CountW'(cfg_i.fail_limit);
    step_idx  = (excess > CountW'(LastStep)) ? LastStep : excess[StepIdxW-1:0];
    dur       = lock_ms_i[step_idx];
    if (arm_cnt < CountW'(cfg_i.fail_limit) || dur == '0) begin
      arm_lock = 1'b0;
      arm_rem  = '0;
    end else begin
      arm_lock = 1'b1;
      arm_rem  = dur;
    end
    rem_dec = (rem_q == '0) ? rem_q : rem_q - MsW'(1);
  end

  always_comb begin
    count_d = count_q;
    rem_d   = rem_q;
    lock_d  = lock_q;
    verdict = VERDICT_NONE;
    user_id = '0;
    persist = 1'b0;
    case (in_q.kind)
      KIND_TICK: begin
        if (lock_q) begin
          rem_d = rem_dec;
          if (rem_dec == '0) begin
            lock_d = 1'b0;
          end
        end
      end
      KIND_REPLY: begin
        if (lock_q) begin
          verdict = VERDICT_LOCKED;
        end else if (in_q.reply_code inside {[MatchCodeLo:MatchCodeHi]}) begin
          verdict = VERDICT_MATCH;
          user_id = {in_q.id_high, in_q.id_low};
          count_d = '0;
          lock_d  = 1'b0;
          rem_d   = '0;
          persist = 1'b1;
        end else if (in_q.reply_code == cfg_i.timeout_code) begin
          verdict = VERDICT_TIMEOUT;
        end else begin
          verdict = VERDICT_FAIL;
          count_d = count_inc;
          lock_d  = arm_lock;
          rem_d   = arm_rem;
          persist = 1'b1;
        end
      end
      KIND_RESTORE: begin
        count_d = in_q.restore_count;
        lock_d  = arm_lock;
        rem_d   = arm_rem;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      mid_valid_q <= 1'b0;
      count_q     <= '0;
      rem_q       <= '0;
      lock_q      <= 1'b0;
    end else begin
      if (en_in) begin
        in_valid_q <= item_i.valid;
      end
      if (en_mid) begin
        mid_valid_q <= in_valid_q;
        if (in_valid_q) begin
          count_q <= count_d;
          rem_q   <= rem_d;
          lock_q  <= lock_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_in && item_i.valid) begin
      in_q.kind          <= item_i.kind;
      in_q.reply_code    <= item_i.reply_code;
      in_q.id_high       <= item_i.id_high;
      in_q.id_low        <= item_i.id_low;
      in_q.restore_count <= item_i.restore_count;
    end
    if (en_mid && in_valid_q) begin
      mid_q.verdict         <= verdict;
      mid_q.user_id         <= user_id;
      mid_q.locked          <= lock_d;
      mid_q.remaining_ms    <= rem_d;
      mid_q.failure_total   <= count_d;
      mid_q.persist_request <= persist;
    end
  end

  assign mid_valid_o = mid_valid_q;
  assign mid_o       = mid_q;

endmodule

// ===== hw/rtl/efl_report.sv =====
// ----------------------------------------------------------------------------
// Lockout result stage
// Converts remaining milliseconds to seconds and holds the result transaction.
// ----------------------------------------------------------------------------
module efl_report
  import efl_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    mid_valid_i,
  output logic    mid_ready_o,
  input  mid_t    mid_i,
  efl_out_if.source result_o
);

  localparam int unsigned MulW = MsW + RecipW;

  logic            out_valid_q;
  res_t            res_q;
  logic            en_out;
  logic [MulW-1:0] prod;
  logic [SecW-1:0] secs;

  assign en_out      = !out_valid_q || result_o.ready;
  assign mid_ready_o = en_out;

  assign prod = MulW'(mid_i.remaining_ms) * MulW'(Recip1000);
  assign secs = mid_i.locked ? SecW'(prod >> RecipShift) + SecW'(1) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_out) begin
      out_valid_q <= mid_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out && mid_valid_i) begin
      res_q.verdict         <= mid_i.verdict;
      res_q.user_id         <= mid_i.user_id;
      res_q.locked          <= mid_i.locked;
      res_q.secs_left       <= secs;
      res_q.failure_total   <= mid_i.failure_total;
      res_q.persist_request <= mid_i.persist_request;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.verdict         = res_q.verdict;
  assign result_o.user_id         = res_q.user_id;
  assign result_o.locked          = res_q.locked;
  assign result_o.secs_left       = res_q.secs_left;
  assign result_o.failure_total   = res_q.failure_total;
  assign result_o.persist_request = res_q.persist_request;

endmodule

// ===== hw/rtl/escalating_failure_lockout_core.sv =====
// ----------------------------------------------------------------------------
// Escalating failure lockout core
// Brute-force guard that counts failed matches and times escalating lockouts.
// ----------------------------------------------------------------------------
// The item_i channel takes one transaction per millisecond tick, matcher
// reply or restore of a saved failure count; every accepted transaction
// yields exactly one transaction on result_o, in order.
// A transaction passes an input register, the state update register and a
// result register. One transaction is taken in every cycle while result_o
// is not stalled; the state update is combinational on the input register,
// so consecutive items never wait on each other.
// The seconds figure is formed by a reciprocal multiply in the last stage.
// Each stage refills as soon as its successor has room, so the block keeps
// accepting while a result waits; when result_o stalls with all three
// stages full, item_i.ready drops until the receiver takes a result.
// Reset clears the failure count, the lock and all stage valids, and loads
// the default threshold, timeout code and duration table. The user must write
// the cfg port only while no transaction is in flight (not enforced here).
// ----------------------------------------------------------------------------
module escalating_failure_lockout_core
  import efl_pkg::*;
#(
  parameter int unsigned STEP_COUNT = StepCountDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  efl_in_if.sink             item_i,
  efl_out_if.source          result_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  cfg_t           cfg;
  logic [MsW-1:0] lock_ms [STEP_COUNT];
  logic           mid_valid;
  logic           mid_ready;
  mid_t           mid;

  efl_cfg #(
    .STEP_COUNT (STEP_COUNT)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .lock_ms_o   (lock_ms)
  );

  efl_update #(
    .STEP_COUNT (STEP_COUNT)
  ) u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_i       (cfg),
    .lock_ms_i   (lock_ms),
    .mid_valid_o (mid_valid),
    .mid_ready_i (mid_ready),
    .mid_o       (mid)
  );

  efl_report u_report (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_valid_i (mid_valid),
    .mid_ready_o (mid_ready),
    .mid_i       (mid),
    .result_o    (result_o)
  );

endmodule

// ===== hw/rtl/efl_checks.sv =====
// ----------------------------------------------------------------------------
// Lockout port checks
// Concurrent checks on the result channel of the lockout core.
// ----------------------------------------------------------------------------
module efl_checks
  import efl_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [2:0]  res_verdict_i,
  input logic [15:0] res_user_id_i,
  input logic        res_locked_i,
  input logic [14:0] res_seconds_i,
  input logic [15:0] res_total_i,
  input logic        res_persist_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_verdict_i)
      && $stable(res_total_i) && $stable(res_seconds_i))
    else $error("Stalled result transaction changed.");

  a_seconds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_locked_i == (res_seconds_i != '0)))
    else $error("Seconds left disagrees with the lock state.");

  a_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_verdict_i == VERDICT_MATCH
      |-> res_total_i == '0 && !res_locked_i && res_persist_i)
    else $error("Match did not clear the count and the lock.");

  a_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_verdict_i == VERDICT_LOCKED |-> res_locked_i && !res_persist_i)
    else $error("Reply ignored while locked changed the state.");

  a_persist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_persist_i == (res_verdict_i == VERDICT_MATCH
      || res_verdict_i == VERDICT_FAIL)
      && (res_verdict_i == VERDICT_MATCH || res_user_id_i == '0))
    else $error("Persist request or user id inconsistent with verdict.");

endmodule

bind escalating_failure_lockout_core efl_checks u_efl_checks (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (result_o.valid),
  .res_ready_i   (result_o.ready),
  .res_verdict_i (result_o.verdict),
  .res_user_id_i (result_o.user_id),
  .res_locked_i  (result_o.locked),
  .res_seconds_i (result_o.secs_left),
  .res_total_i   (result_o.failure_total),
  .res_persist_i (result_o.persist_request)
);

// ===== test/escalating_failure_lockout_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escalating failure lockout core testbench
// Drives ticks, matcher replies and count restores into the core under
// several register settings, predicts every status transaction with a
// behavioral model of the lockout, and compares each result field by field.
// ----------------------------------------------------------------------------
module escalating_failure_lockout_core_tb;
  import efl_pkg::*;

  localparam logic [KindW-1:0]   KindUnused    = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused  = 3'd7;
  localparam int unsigned        WatchdogLimit = 3000;
  localparam int unsigned        ItemsPerPhase = 110;

  class lockout_scoreboard;
    logic [CodeW-1:0]  threshold;
    logic [CodeW-1:0]  timeout_code;
    logic [MsW-1:0]    durations [StepMax];
    logic [CountW-1:0] fail_count;
    logic [MsW-1:0]    remaining;
    logic              lock_on;
    res_t              pending_status [$];
    int unsigned       errors;

    function new();
      threshold    = FailThresholdRst;
      timeout_code = TimeoutCodeRst;
      foreach (durations[i]) durations[i] = LockMsRst[i];
      fail_count = '0;
      remaining  = '0;
      lock_on    = 1'b0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      if (idx == CFG_FAIL_THRESHOLD) begin
        threshold = data[CodeW-1:0];
      end else if (idx == CFG_TIMEOUT_CODE) begin
        timeout_code = data[CodeW-1:0];
      end else if (idx >= CFG_LOCK_MS_STEP0 && idx < CFG_LOCK_MS_STEP0 + StepMax) begin
        durations[idx - CFG_LOCK_MS_STEP0] = data[MsW-1:0];
      end
    endfunction

    function void arm_lock();
      int unsigned excess;
      if (fail_count < threshold) begin
        lock_on   = 1'b0;
        remaining = '0;
        return;
      end
      excess = fail_count - threshold;
      if (excess > StepCountDef - 1) excess = StepCountDef - 1;
      remaining = durations[excess];
      lock_on   = (remaining != '0);
    endfunction

    function void predict_status(item_t it);
      res_t st;
      st         = '0;
      st.verdict = VERDICT_NONE;
      case (it.kind)
        KIND_TICK: begin
          if (lock_on) begin
            if (remaining != '0) remaining--;
            if (remaining == '0) lock_on = 1'b0;
          end
        end
        KIND_REPLY: begin
          if (lock_on) begin
            st.verdict = VERDICT_LOCKED;
          end else if (it.reply_code >= MatchCodeLo && it.reply_code <= MatchCodeHi) begin
            st.verdict         = VERDICT_MATCH;
            st.user_id         = {it.id_high, it.id_low};
            fail_count         = '0;
            lock_on            = 1'b0;
            remaining          = '0;
            st.persist_request = 1'b1;
          end else if (it.reply_code == timeout_code) begin
            st.verdict = VERDICT_TIMEOUT;
          end else begin
            st.verdict = VERDICT_FAIL;
            if (fail_count != '1) fail_count++;
            st.persist_request = 1'b1;
            arm_lock();
          end
        end
        KIND_RESTORE: begin
          fail_count = it.restore_count;
          arm_lock();
        end
        default: ;
      endcase
      st.locked        = lock_on;
      st.secs_left     = lock_on ? SecW'(remaining / 1000 + 1) : '0;
      st.failure_total = fail_count;
      pending_status.push_back(st);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_status(res_t got);
      res_t want;
      if (pending_status.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual verdict %0d",
                 $time, got.verdict);
        return;
      end
      want = pending_status.pop_front();
      compare_field("verdict", want.verdict, got.verdict);
      compare_field("user_id", want.user_id, got.user_id);
      compare_field("locked", want.locked, got.locked);
      compare_field("secs_left", want.secs_left, got.secs_left);
      compare_field("failure_total", want.failure_total, got.failure_total);
      compare_field("persist_request", want.persist_request, got.persist_request);
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_wdata;
  bit                 no_gaps = 1'b0;
  int unsigned        quiet_cycles = 0;
  lockout_scoreboard  sb;

  efl_in_if  item_if ();
  efl_out_if res_if ();

  escalating_failure_lockout_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_if),
    .result_o    (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic item_t mk(logic [KindW-1:0] kind, logic [CodeW-1:0] code,
                               logic [ByteW-1:0] idh, logic [ByteW-1:0] idl,
                               logic [CountW-1:0] rest);
    item_t it;
    it.kind          = kind;
    it.reply_code    = code;
    it.id_high       = idh;
    it.id_low        = idl;
    it.restore_count = rest;
    return it;
  endfunction

  function automatic item_t rand_item();
    item_t       it;
    int unsigned r;
    int unsigned near;
    it = mk(KIND_TICK, CodeW'($urandom), ByteW'($urandom), ByteW'($urandom),
            CountW'($urandom));
    r  = $urandom_range(99);
    if (r < 45) begin
      it.kind = KIND_TICK;
    end else if (r < 85) begin
      it.kind = KIND_REPLY;
      r = $urandom_range(99);
      if (r < 20) it.reply_code = CodeW'($urandom_range(MatchCodeLo, MatchCodeHi));
      else if (r < 35) it.reply_code = sb.timeout_code;
    end else if (r < 95) begin
      it.kind = KIND_RESTORE;
      r = $urandom_range(99);
      if (r < 50) begin
        near = sb.threshold + $urandom_range(0, 6);
        it.restore_count = CountW'(near);
      end else if (r < 70) begin
        it.restore_count = CountW'($urandom_range(0, sb.threshold));
      end else if (r < 80) begin
        it.restore_count = CountW'(16'hFFFF - $urandom_range(0, 1));
      end
    end else begin
      it.kind = KindUnused;
    end
    return it;
  endfunction

  function automatic logic [MsW-1:0] pick_dur();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return '0;
    if (r < 35) return '1;
    return MsW'($urandom_range(1, 20));
  endfunction

  task automatic send_txn(input item_t it);
    if (!no_gaps) begin
      while ($urandom_range(99) < 17) begin
        item_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    item_if.valid         <= 1'b1;
    item_if.kind          <= it.kind;
    item_if.reply_code    <= it.reply_code;
    item_if.id_high       <= it.id_high;
    item_if.id_low        <= it.id_low;
    item_if.restore_count <= it.restore_count;
    do @(posedge clk_i); while (!item_if.ready);
    sb.predict_status(it);
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) send_txn(rand_item());
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic set_phase(input logic [CodeW-1:0] thr, input logic [MsW-1:0] d0,
                           input logic [MsW-1:0] d1, input logic [MsW-1:0] d2,
                           input logic [MsW-1:0] d3, input logic [MsW-1:0] d4,
                           input logic [CodeW-1:0] tcode);
    item_if.valid <= 1'b0;
    while (sb.pending_status.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    write_reg(CFG_FAIL_THRESHOLD, {16'($urandom), thr});
    write_reg(CFG_LOCK_MS_STEP0, d0);
    write_reg(CFG_LOCK_MS_STEP0 + 3'd1, d1);
    write_reg(CFG_LOCK_MS_STEP0 + 3'd2, d2);
    write_reg(CFG_LOCK_MS_STEP0 + 3'd3, d3);
    write_reg(CFG_LOCK_MS_STEP0 + 3'd4, d4);
    write_reg(CFG_TIMEOUT_CODE, {16'($urandom), tcode});
    write_reg(CfgIdxUnused, CfgW'($urandom));
    cfg_we <= 1'b0;
  endtask

  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= no_gaps || ($urandom_range(99) >= 17);
    end
  end

  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.verdict         = verdict_e'(res_if.verdict);
      got.user_id         = res_if.user_id;
      got.locked          = res_if.locked;
      got.secs_left       = res_if.secs_left;
      got.failure_total   = res_if.failure_total;
      got.persist_request = res_if.persist_request;
      sb.check_status(got);
    end
  end

  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sb = new();
    rst_ni                <= 1'b0;
    item_if.valid         <= 1'b0;
    item_if.kind          <= '0;
    item_if.reply_code    <= '0;
    item_if.id_high       <= '0;
    item_if.id_low        <= '0;
    item_if.restore_count <= '0;
    cfg_we                <= 1'b0;
    cfg_idx               <= '0;
    cfg_wdata             <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: matches, failures, timeout, lock entry and restores.
    send_txn(mk(KIND_TICK, 8'h00, 8'h00, 8'h00, 16'h0000));
    send_txn(mk(KIND_REPLY, 8'h00, 8'hFF, 8'hFF, 16'hFFFF));
    send_txn(mk(KIND_REPLY, TimeoutCodeRst, 8'h12, 8'h34, 16'h0000));
    send_txn(mk(KIND_REPLY, MatchCodeLo, 8'hFF, 8'h00, 16'h0000));
    send_txn(mk(KIND_REPLY, 8'h55, 8'h00, 8'h00, 16'h0000));
    send_txn(mk(KIND_REPLY, MatchCodeHi, 8'h00, 8'hFF, 16'h0000));
    send_txn(mk(KIND_REPLY, 8'hFF, 8'hA5, 8'h5A, 16'h0000));
    send_txn(mk(KIND_RESTORE, 8'h00, 8'h00, 8'h00, 16'd4));
    send_txn(mk(KIND_REPLY, 8'hAA, 8'h00, 8'h00, 16'h0000));
    send_txn(mk(KIND_REPLY, 8'd2, 8'hBE, 8'hEF, 16'h0000));
    send_txn(mk(KIND_TICK, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
    send_txn(mk(KindUnused, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
    send_txn(mk(KIND_RESTORE, 8'h00, 8'h00, 8'h00, 16'hFFFF));
    send_txn(mk(KIND_RESTORE, 8'h00, 8'h00, 8'h00, 16'h0000));
    send_txn(mk(KIND_RESTORE, 8'h00, 8'h00, 8'h00, 16'd6));

    // Zero threshold, zero durations and a timeout code inside the match range.
    set_phase(8'd0, 24'd2, 24'd0, 24'd1, 24'd3, 24'd0, 8'd2);
    send_txn(mk(KIND_RESTORE, 8'h00, 8'h00, 8'h00, 16'd0));
    send_txn(mk(KIND_TICK, 8'h00, 8'h00, 8'h00, 16'h0000));
    send_txn(mk(KIND_TICK, 8'h00, 8'h00, 8'h00, 16'h0000));
    send_txn(mk(KIND_REPLY, 8'd2, 8'h80, 8'h01, 16'h0000));
    send_txn(mk(KIND_RESTORE, 8'h00, 8'h00, 8'h00, 16'hFFFE));
    send_txn(mk(KIND_REPLY, 8'h10, 8'h00, 8'h00, 16'h0000));
    send_txn(mk(KIND_REPLY, 8'h11, 8'h00, 8'h00, 16'h0000));
    send_txn(mk(KIND_RESTORE, 8'h00, 8'h00, 8'h00, 16'd1));
    send_txn(mk(KIND_RESTORE, 8'h00, 8'h00, 8'h00, 16'd2));
    send_txn(mk(KIND_TICK, 8'h00, 8'h00, 8'h00, 16'h0000));

    set_phase(8'd1, 24'd1, 24'd2, 24'd3, 24'd5, 24'd8, 8'd0);
    run_random(ItemsPerPhase);

    set_phase(8'd255, 24'd1, 24'd0, 24'd4, 24'hFFFFFF, 24'd2, 8'd255);
    run_random(ItemsPerPhase);

    set_phase(8'd3, MsW'($urandom_range(0, 30)), MsW'($urandom_range(0, 30)),
              MsW'($urandom_range(0, 30)), MsW'($urandom_range(0, 30)),
              MsW'($urandom_range(0, 30)), CodeW'($urandom));
    no_gaps = 1'b1;
    run_random(ItemsPerPhase);
    no_gaps = 1'b0;

    set_phase(CodeW'($urandom_range(1, 255)), pick_dur(), pick_dur(), pick_dur(),
              pick_dur(), pick_dur(), CodeW'($urandom));
    run_random(ItemsPerPhase);

    set_phase(8'd4, 24'd6, 24'd0, 24'd1001, 24'd1, 24'd12, CodeW'($urandom));
    run_random(ItemsPerPhase);

    item_if.valid <= 1'b0;
    while (sb.pending_status.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_status.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/efl_pkg.sv
hw/rtl/efl_in_if.sv
hw/rtl/efl_out_if.sv
hw/rtl/efl_cfg.sv
hw/rtl/efl_update.sv
hw/rtl/efl_report.sv
hw/rtl/escalating_failure_lockout_core.sv
hw/rtl/efl_checks.sv
test/escalating_failure_lockout_core_tb.sv
